/* hw/rtl/mb422_pkg.sv */
package mb422_pkg;

  localparam int unsigned ADDR_W   = 21;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned CFG_W    = 21;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned OFS_W    = 9;
  localparam int unsigned K_W      = 6;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CNT_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CNT_Y = 2'd2;

  // byte positions inside one macroblock
  localparam logic [OFS_W-1:0] V_START = 9'd64;
  localparam logic [OFS_W-1:0] Y_START = 9'd128;
  localparam logic [OFS_W-1:0] MB_LAST = 9'd383;
  localparam logic [K_W-1:0]   K_LAST  = 6'd63;

  // one macroblock's worth of work for the back end
  typedef struct packed {
    logic [ADDR_W-1:0] origin;
    logic              done;
    logic              overrun;
    logic              bank;
  } job_t;

  // sample store write: U/V take data[15:0] at {bank, idx[4:0]}, Y all 32 bits
  typedef struct packed {
    logic              u_we;
    logic              v_we;
    logic              y_we;
    logic              bank;
    logic [5:0]        idx;
    logic [31:0]       data;
  } store_wr_t;

  typedef struct packed {
    logic              re;
    logic              bank;
    logic [4:0]        c_idx;
    logic [5:0]        y_idx;
  } store_rd_t;

  typedef struct packed {
    logic [15:0]       u;
    logic [15:0]       v;
    logic [31:0]       y;
  } store_dat_t;

  typedef struct packed {
    logic              valid;
    logic              bank;
  } release_t;

endpackage

/* hw/rtl/mb422_byte_if.sv */
interface mb422_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

/* hw/rtl/mb422_result_if.sv */
interface mb422_result_if;
  import mb422_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] word_addr;
  logic [WORD_W-1:0] word_even;
  logic [WORD_W-1:0] word_odd;
  logic              last_of_block;
  logic              frame_done;
  logic              overrun;

  modport source (output valid, output word_addr, output word_even, output word_odd,
                  output last_of_block, output frame_done, output overrun, input ready);
  modport sink (input valid, input word_addr, input word_even, input word_odd,
                input last_of_block, input frame_done, input overrun, output ready);
endinterface

/* hw/rtl/mb422_store.sv */
module mb422_store (
  input  logic                   clk,
  input  mb422_pkg::store_wr_t   wr,
  input  mb422_pkg::store_rd_t   rd,
  output mb422_pkg::store_dat_t  dat
);
  import mb422_pkg::*;

  // two banks each: U/V as sample pairs, Y as four-sample words
  logic [15:0] u_mem [64];
  logic [15:0] v_mem [64];
  logic [31:0] y_mem [128];

  // write port
  always_ff @(posedge clk) begin
    if (wr.u_we) begin
      u_mem[{wr.bank, wr.idx[4:0]}] <= wr.data[15:0];
    end
    if (wr.v_we) begin
      v_mem[{wr.bank, wr.idx[4:0]}] <= wr.data[15:0];
    end
    if (wr.y_we) begin
      y_mem[{wr.bank, wr.idx}] <= wr.data;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk) begin
    if (rd.re) begin
      dat.u <= u_mem[{rd.bank, rd.c_idx}];
      dat.v <= v_mem[{rd.bank, rd.c_idx}];
      dat.y <= y_mem[{rd.bank, rd.y_idx}];
    end
  end

endmodule

/* hw/rtl/mb422_queue.sv */
module mb422_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mb422_pkg::job_t  job_in,
  input  logic             pop,
  output mb422_pkg::job_t  head,
  output logic             empty,
  output logic             full
);
  import mb422_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_QW = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  job_t              slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_QW-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CNT_QW'(DEPTH));
  assign head  = slots[rd_ptr];

  // store pushed job
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= job_in;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("job pushed into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("job popped from empty queue");

endmodule

/* hw/rtl/mb422_front.sv */
module mb422_front (
  input  logic                          clk,
  input  logic                          rst,
  mb422_byte_if.sink                    stream,
  input  logic                          cfg_we,
  input  logic [mb422_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mb422_pkg::CFG_W-1:0]   cfg_data,
  input  logic                          q_full,
  output logic                          push,
  output mb422_pkg::job_t               job,
  input  mb422_pkg::release_t           rel,
  output mb422_pkg::store_wr_t          wr
);
  import mb422_pkg::*;

  logic [ADDR_W-1:0] base;
  logic [CNT_W-1:0]  cnt_x;
  logic [CNT_W-1:0]  cnt_y;
  logic [OFS_W-1:0]  byte_offset;
  logic [5:0]        block_x;
  logic [6:0]        block_y;
  logic              wbank;
  logic [1:0]        bank_busy;
  logic [1:0]        bank_busy_next;
  logic [23:0]       hold;

  logic              accept;
  logic              mb_end;
  logic [6:0]        nx;
  logic [6:0]        ny;
  logic              x_wrap;
  logic [7:0]        y_byte;

  // take bytes while the write bank is free and the queue has room
  assign stream.ready = !bank_busy[wbank] && !q_full;
  assign accept       = stream.valid && stream.ready;
  assign mb_end       = accept && (byte_offset == MB_LAST);

  // next position
  assign nx     = {1'b0, block_x} + 7'd1;
  assign ny     = block_y + 7'd1;
  assign x_wrap = (nx >= cnt_x) || nx[6];

  // job for a completed macroblock
  assign push        = mb_end;
  assign job.overrun = (block_y >= cnt_y);
  assign job.origin  = base + {2'b00, block_y, 12'd0} + {12'd0, block_x, 3'd0};
  assign job.done    = ((x_wrap ? ny : block_y) >= cnt_y);
  assign job.bank    = wbank;

  // steer the byte into the sample stores
  assign y_byte = {~byte_offset[7], byte_offset[6:0]};
  always_comb begin
    wr.u_we = 1'b0;
    wr.v_we = 1'b0;
    wr.y_we = 1'b0;
    wr.bank = wbank;
    wr.idx  = {1'b0, byte_offset[5:1]};
    wr.data = {8'd0, 8'd0, stream.data_byte, hold[23:16]};
    if (byte_offset < V_START) begin
      wr.u_we = accept && byte_offset[0];
    end else if (byte_offset < Y_START) begin
      wr.v_we = accept && byte_offset[0];
    end else begin
      wr.y_we = accept && (y_byte[1:0] == 2'b11);
      wr.idx  = y_byte[7:2];
      wr.data = {stream.data_byte, hold};
    end
  end

  // collect bytes until a store word is complete
  always_ff @(posedge clk) begin
    if (accept) begin
      hold <= {stream.data_byte, hold[23:8]};
    end
  end

  // mark banks in use until the back end has read them out
  always_comb begin
    bank_busy_next = bank_busy;
    if (rel.valid) begin
      bank_busy_next[rel.bank] = 1'b0;
    end
    if (mb_end && !job.overrun) begin
      bank_busy_next[wbank] = 1'b1;
    end
  end

  // stream position, registers and bank control
  always_ff @(posedge clk) begin
    if (rst) begin
      base        <= '0;
      cnt_x       <= 7'd1;
      cnt_y       <= 7'd1;
      byte_offset <= '0;
      block_x     <= '0;
      block_y     <= '0;
      wbank       <= 1'b0;
      bank_busy   <= '0;
    end else begin
      bank_busy <= bank_busy_next;
      if (accept) begin
        byte_offset <= mb_end ? '0 : byte_offset + 1'b1;
      end
      if (mb_end && !job.overrun) begin
        wbank <= ~wbank;
        if (x_wrap) begin
          block_x <= '0;
          block_y <= ny;
        end else begin
          block_x <= nx[5:0];
        end
      end
      // a write to any listed register restarts the stream
      if (cfg_we) begin
        case (cfg_index)
          REG_BASE: begin
            base        <= cfg_data;
            byte_offset <= '0;
            block_x     <= '0;
            block_y     <= '0;
          end
          REG_CNT_X: begin
            cnt_x       <= cfg_data[CNT_W-1:0];
            byte_offset <= '0;
            block_x     <= '0;
            block_y     <= '0;
          end
          REG_CNT_Y: begin
            cnt_y       <= cfg_data[CNT_W-1:0];
            byte_offset <= '0;
            block_x     <= '0;
            block_y     <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

/* hw/rtl/mb422_back.sv */
module mb422_back (
  input  logic                   clk,
  input  logic                   rst,
  input  mb422_pkg::job_t        head,
  input  logic                   q_empty,
  output logic                   pop,
  output mb422_pkg::release_t    rel,
  output mb422_pkg::store_rd_t   rd,
  input  mb422_pkg::store_dat_t  dat,
  mb422_result_if.source         result
);
  import mb422_pkg::*;

  logic [K_W-1:0]    k;
  logic              out_valid;
  logic [ADDR_W-1:0] addr_r;
  logic              last_r;
  logic              done_r;
  logic              ovr_r;
  logic              issue;
  logic              job_end;

  // issue one result when a job waits and the output register frees up
  assign issue   = !q_empty && (!out_valid || result.ready);
  assign job_end = head.overrun || (k == K_LAST);
  assign pop     = issue && job_end;

  assign rel.valid = pop && !head.overrun;
  assign rel.bank  = head.bank;

  // row r = k[5:2], pair column k[1:0]
  assign rd.re    = issue && !head.overrun;
  assign rd.bank  = head.bank;
  assign rd.c_idx = {k[5:3], k[1:0]};
  assign rd.y_idx = {k[5], k[1], k[4:2], k[0]};

  // walk the 64 results of a job, or the single result of an overrun job
  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (issue) begin
        k <= job_end ? '0 : k + 1'b1;
      end
      if (issue) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // side fields travel next to the store read data
  always_ff @(posedge clk) begin
    if (issue) begin
      addr_r <= head.overrun ? '0
              : head.origin + {9'd0, k[5:2], 5'd0, k[1:0], 1'b0};
      last_r <= job_end;
      done_r <= !head.overrun && (k == K_LAST) && head.done;
      ovr_r  <= head.overrun;
    end
  end

  assign result.valid         = out_valid;
  assign result.word_addr     = addr_r;
  assign result.word_even     = ovr_r ? '0 : {dat.y[15:8], dat.v[7:0], dat.y[7:0], dat.u[7:0]};
  assign result.word_odd      = ovr_r ? '0
                              : {dat.y[31:24], dat.v[15:8], dat.y[23:16], dat.u[15:8]};
  assign result.last_of_block = last_r;
  assign result.frame_done    = done_r;
  assign result.overrun       = ovr_r;

  a_mid_job_head: assert property (@(posedge clk) disable iff (rst) (k != '0) |-> !q_empty)
    else $error("job left the queue before its last result");
  a_overrun_single: assert property (@(posedge clk) disable iff (rst)
      (issue && head.overrun) |=> (result.overrun && result.last_of_block && !result.frame_done))
    else $error("overrun result malformed");
  a_done_on_last: assert property (@(posedge clk) disable iff (rst)
      (result.valid && result.frame_done) |-> result.last_of_block)
    else $error("frame done away from last result");

endmodule

/* hw/rtl/yuv420_macroblock_to_yuv422_unit.sv */
// A macroblock's job is queued when its 384th byte transfers; the back end reads
// the store into the output register: 64 results (one on overrun), one per cycle
// while the receiver is ready. Throughput: one byte per cycle while the write bank
// is free and the queue has room; one store bank drains while the other fills.
// Reset: registers return to base 0 and a 1x1 frame, position and queue clear,
// both banks free; sample stores are not cleared.
module yuv420_macroblock_to_yuv422_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                            clk,
  input  logic                            rst,
  mb422_byte_if.sink                      stream,
  mb422_result_if.source                  result,
  input  logic                            cfg_we,
  input  logic [mb422_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mb422_pkg::CFG_W-1:0]     cfg_data
);
  import mb422_pkg::*;

  job_t       job;
  job_t       head;
  logic       push;
  logic       pop;
  logic       q_empty;
  logic       q_full;
  release_t   rel;
  store_wr_t  wr;
  store_rd_t  rd;
  store_dat_t dat;

  mb422_front u_front (
    .clk       (clk),
    .rst       (rst),
    .stream    (stream),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .job       (job),
    .rel       (rel),
    .wr        (wr)
  );

  mb422_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .job_in (job),
    .pop    (pop),
    .head   (head),
    .empty  (q_empty),
    .full   (q_full)
  );

  mb422_store u_store (
    .clk (clk),
    .wr  (wr),
    .rd  (rd),
    .dat (dat)
  );

  mb422_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .rel     (rel),
    .rd      (rd),
    .dat     (dat),
    .result  (result)
  );

endmodule

/* tb/yuv420_macroblock_to_yuv422_unit_tb.sv */
`timescale 1ns / 1ps

module yuv420_macroblock_to_yuv422_unit_tb;
  import mb422_pkg::*;

  localparam int unsigned ROW_WORDS     = 256;
  localparam int unsigned MB_ROWS       = 16;
  localparam int unsigned MAX_COLS      = 64;
  localparam int unsigned ROW_WRAP      = 128;
  localparam int unsigned MB_BYTES      = MB_LAST + 1;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned LONG_HOLD     = 4000;
  localparam int unsigned RANDOM_PHASES = 12;
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum int unsigned {FILL_ZERO, FILL_ONES, FILL_RAMP, FILL_RANDOM} fill_kind_t;

  typedef struct packed {
    logic [ADDR_W-1:0] word_addr;
    logic [WORD_W-1:0] word_even;
    logic [WORD_W-1:0] word_odd;
    logic              last_of_block;
    logic              frame_done;
    logic              overrun;
  } uyvy_beat_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_data;
  logic              long_hold_req;

  mb422_byte_if   byte_ch ();
  mb422_result_if res_ch ();

  yuv420_macroblock_to_yuv422_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .stream   (byte_ch),
    .result   (res_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // bytes waiting to be offered, and converted words waiting to come out
  logic [7:0]  stream_bytes[$];
  uyvy_beat_t  beats_due[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // converter mirror: registers, position and sample planes
  logic [ADDR_W-1:0] cfg_base = '0;
  int unsigned       cfg_cols = 1;
  int unsigned       cfg_rows = 1;
  int unsigned       pos_col = 0;
  int unsigned       pos_row = 0;
  int unsigned       mb_fill = 0;
  logic [7:0]        u_plane[64];
  logic [7:0]        v_plane[64];
  logic [7:0]        y_plane[256];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // pack one U Y0 V Y1 word from 16x8-word block position (row, word)
  function automatic logic [31:0] uyvy_word(input int unsigned row, input int unsigned col);
    int unsigned quad;
    int unsigned li;
    int unsigned ci;
    quad = (row >= 8 ? 'h80 : 0) + (col >= 4 ? 'h40 : 0);
    li   = ((row % 8) * 8 + (col % 4) * 2 + quad) % 256;
    ci   = ((row / 2) * 8 + col) % 64;
    return {y_plane[(li + 1) % 256], v_plane[ci], y_plane[li], u_plane[ci]};
  endfunction

  // store one byte; on the last byte of a macroblock queue its words
  task automatic convert_byte(input logic [7:0] b);
    int unsigned origin;
    logic        done;
    uyvy_beat_t  beat;
    if (mb_fill < V_START) u_plane[mb_fill] = b;
    else if (mb_fill < Y_START) v_plane[mb_fill - V_START] = b;
    else y_plane[mb_fill - Y_START] = b;
    if (mb_fill != MB_LAST) begin
      mb_fill++;
      return;
    end
    mb_fill = 0;

    // frame already complete: one flag-only result, position holds
    if (pos_row >= cfg_rows) begin
      beat = '0;
      beat.last_of_block = 1'b1;
      beat.overrun = 1'b1;
      beats_due.push_back(beat);
      return;
    end

    origin = cfg_base + pos_row * MB_ROWS * ROW_WORDS + pos_col * 8;
    if (pos_col + 1 >= cfg_cols || pos_col + 1 >= MAX_COLS) begin
      pos_col = 0;
      pos_row = (pos_row + 1) % ROW_WRAP;
    end else begin
      pos_col++;
    end
    done = (pos_row >= cfg_rows);

    for (int unsigned k = 0; k <= K_LAST; k++) begin
      beat.word_addr     = ADDR_W'(origin + (k / 4) * ROW_WORDS + (k % 4) * 2);
      beat.word_even     = uyvy_word(k / 4, (k % 4) * 2);
      beat.word_odd      = uyvy_word(k / 4, (k % 4) * 2 + 1);
      beat.last_of_block = (k == K_LAST);
      beat.frame_done    = (k == K_LAST) && done;
      beat.overrun       = 1'b0;
      beats_due.push_back(beat);
    end
  endtask

  function automatic int unsigned pick_gap(input bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 2);
    return $urandom_range(6, 12);
  endfunction

  // byte driver: offer queued bytes with random gaps between transfers
  int unsigned src_gap = 0;
  int unsigned src_mode_left = 0;
  bit          src_steady = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      byte_ch.valid     <= 1'b0;
      byte_ch.data_byte <= '0;
      src_gap = 0;
    end else begin
      if (src_mode_left == 0) begin
        src_steady    = ($urandom_range(0, 3) == 0);
        src_mode_left = $urandom_range(200, 800);
      end else begin
        src_mode_left--;
      end
      // hold the byte while it is not taken
      if (!byte_ch.valid || byte_ch.ready) begin
        if (byte_ch.valid) src_gap = pick_gap(src_steady);
        if (src_gap == 0 && stream_bytes.size() != 0) begin
          byte_ch.valid     <= 1'b1;
          byte_ch.data_byte <= stream_bytes.pop_front();
        end else begin
          byte_ch.valid <= 1'b0;
          if (src_gap > 0) src_gap--;
        end
      end
    end
  end

  // result ready: random stalls, plus one long hold on request
  int unsigned snk_stall = 0;
  int unsigned snk_mode_left = 0;
  bit          snk_steady = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      snk_stall = 0;
    end else begin
      if (snk_mode_left == 0) begin
        snk_steady    = ($urandom_range(0, 3) == 0);
        snk_mode_left = $urandom_range(200, 800);
      end else begin
        snk_mode_left--;
      end
      if (long_hold_req) snk_stall = LONG_HOLD;
      if (snk_stall > 0) begin
        snk_stall--;
        res_ch.ready <= 1'b0;
      end else begin
        snk_stall = pick_gap(snk_steady);
        res_ch.ready <= (snk_stall == 0);
      end
    end
  end

  // predict on every byte transfer
  always @(posedge clk) begin
    if (!rst && byte_ch.valid && byte_ch.ready) convert_byte(byte_ch.data_byte);
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin : result_check
    uyvy_beat_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (beats_due.size() == 0) begin
        $error("result with none due: word_addr 0x%0h", res_ch.word_addr);
        mismatch_count++;
      end else begin
        want = beats_due.pop_front();
        check_field("word_addr", want.word_addr, res_ch.word_addr);
        check_field("word_even", want.word_even, res_ch.word_even);
        check_field("word_odd", want.word_odd, res_ch.word_odd);
        check_field("last_of_block", want.last_of_block, res_ch.last_of_block);
        check_field("frame_done", want.frame_done, res_ch.frame_done);
        check_field("overrun", want.overrun, res_ch.overrun);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("yuv420_macroblock_to_yuv422_unit_tb: FAIL");
    $finish;
  end

  task automatic queue_bytes(input int unsigned count, input fill_kind_t kind);
    for (int unsigned i = 0; i < count; i++) begin
      case (kind)
        FILL_ZERO: stream_bytes.push_back(8'h00);
        FILL_ONES: stream_bytes.push_back(8'hFF);
        FILL_RAMP: stream_bytes.push_back(8'(i * 3 + 1));
        default:   stream_bytes.push_back(8'($urandom));
      endcase
    end
  endtask

  // wait for every byte to transfer and every due result to arrive
  task automatic drain();
    while (stream_bytes.size() != 0 || byte_ch.valid || beats_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_BASE:  cfg_base = value[ADDR_W-1:0];
      REG_CNT_X: cfg_cols = value[CNT_W-1:0];
      REG_CNT_Y: cfg_rows = value[CNT_W-1:0];
      default: ;
    endcase
    // any real register restarts the stream at position zero
    if (idx != REG_UNUSED) begin
      mb_fill = 0;
      pos_col = 0;
      pos_row = 0;
    end
  endtask

  // frame size: mostly small, sometimes zero or past the 64 limit, junk in high bits
  function automatic logic [CFG_W-1:0] pick_count(input int unsigned max_small);
    int unsigned r;
    logic [CFG_W-1:0] v;
    r = $urandom_range(0, 9);
    if (r == 0) v = '0;
    else if (r == 1) v = CFG_W'($urandom_range(65, 127));
    else v = CFG_W'($urandom_range(1, max_small));
    if ($urandom_range(0, 3) == 0) v[CFG_W-1:CNT_W] = (CFG_W - CNT_W)'($urandom);
    return v;
  endfunction

  initial begin
    int unsigned n_mb;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_BASE;
    cfg_data      = '0;
    long_hold_req = 1'b0;
    byte_ch.valid = 1'b0;
    byte_ch.data_byte = '0;
    res_ch.ready  = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset setup, 1x1 frame: all-ones block completes the frame
    queue_bytes(MB_BYTES, FILL_ONES);
    drain();
    // frame complete: next block overruns
    queue_bytes(MB_BYTES, FILL_ZERO);
    drain();
    // unused index leaves the position alone, still overrun
    write_reg(REG_UNUSED, {CFG_W{1'b1}});
    queue_bytes(MB_BYTES, FILL_RAMP);
    drain();

    // top base wraps the address; zero width acts as one column
    write_reg(REG_BASE, {CFG_W{1'b1}});
    write_reg(REG_CNT_X, 21'h1FFF80);
    write_reg(REG_CNT_Y, 21'd2);
    queue_bytes(MB_BYTES, FILL_RAMP);
    queue_bytes(MB_BYTES, FILL_RANDOM);
    drain();

    // zero height: every block overruns
    write_reg(REG_CNT_Y, 21'h1FFF80);
    queue_bytes(MB_BYTES, FILL_RANDOM);
    drain();

    // oversized width acts as 64 columns; long receiver hold backs up the input
    write_reg(REG_BASE, 21'h0ABCDE);
    write_reg(REG_CNT_X, 21'd100);
    write_reg(REG_CNT_Y, 21'd1);
    for (int i = 0; i <= MAX_COLS; i++) queue_bytes(MB_BYTES, FILL_RANDOM);
    long_hold_req <= 1'b1;
    @(posedge clk);
    long_hold_req <= 1'b0;
    drain();
    // broken block, then a restart by the next write
    queue_bytes(200, FILL_RANDOM);
    drain();

    // random setups and streams
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 4) == 0)
          write_reg(REG_BASE, {CFG_W{1'b1}} - CFG_W'($urandom_range(0, 300)));
        else
          write_reg(REG_BASE, CFG_W'($urandom));
      end
      if ($urandom_range(0, 3) != 0) write_reg(REG_CNT_X, pick_count(4));
      if ($urandom_range(0, 3) != 0) write_reg(REG_CNT_Y, pick_count(3));
      if ($urandom_range(0, 5) == 0) write_reg(REG_UNUSED, CFG_W'($urandom));
      n_mb = $urandom_range(1, 4);
      for (int unsigned m = 0; m < n_mb; m++) begin
        if ($urandom_range(0, 4) == 0) queue_bytes(MB_BYTES, fill_kind_t'($urandom_range(0, 3)));
        else queue_bytes(MB_BYTES, FILL_RANDOM);
        // pause the sender until the block has emptied
        if ($urandom_range(0, 4) == 0) drain();
      end
      if ($urandom_range(0, 4) == 0) queue_bytes($urandom_range(1, MB_LAST), FILL_RANDOM);
      drain();
    end

    if (mismatch_count == 0) begin
      $display("yuv420_macroblock_to_yuv422_unit_tb: PASS");
    end else begin
      $display("yuv420_macroblock_to_yuv422_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/mb422_pkg.sv
hw/rtl/mb422_byte_if.sv
hw/rtl/mb422_result_if.sv
hw/rtl/mb422_store.sv
hw/rtl/mb422_queue.sv
hw/rtl/mb422_front.sv
hw/rtl/mb422_back.sv
hw/rtl/yuv420_macroblock_to_yuv422_unit.sv
tb/yuv420_macroblock_to_yuv422_unit_tb.sv
